// ===== design/voice_frame_receive_deframer_defines.svh =====
// Assertion macros used by the deframer top level.
`ifndef VOICE_FRAME_RECEIVE_DEFRAMER_DEFINES_SVH
`define VOICE_FRAME_RECEIVE_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define VFRD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer check failed");

`define VFRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define VFRD_ASSERT_SAME(label, clk, rstn, ante, cons)

`define VFRD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/vfrd_pkg.sv =====
`timescale 1ns / 1ps

package vfrd_pkg;

    localparam int PAYLOAD_BYTES = 33;
    localparam int FRAME_BYTES   = 53;
    localparam int PAYLOAD_START = 20;
    localparam int TAG_BYTES     = 4;
    localparam int POS_SRC_LO    = 5;
    localparam int POS_SRC_HI    = 7;
    localparam int POS_TGT_LO    = 8;
    localparam int POS_TGT_HI    = 10;
    localparam int POS_FLAGS     = 15;

    localparam int POS_W   = 6;
    localparam int IDX_W   = 6;
    localparam int MEM_DEPTH = 2 * PAYLOAD_BYTES;
    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0]  FTYPE_CTRL        = 2'd2;
    localparam logic [1:0]  FTYPE_DATA        = 2'd3;
    localparam logic [3:0]  DT_HEADER         = 4'd1;
    localparam logic [3:0]  DT_TERMINATOR     = 4'd2;
    localparam logic [1:0]  SKIP_AFTER_HEADER = 2'd3;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;

    localparam logic REG_RX_ENABLED = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_END     = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_END        = 2'd1,
        OP_VOICE_OPEN = 2'd2,
        OP_VOICE      = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [23:0] src;
        logic [23:0] tgt;
        logic        bank;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic done;
        logic bank;
    } back_stat_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h44;
            2'd1: b = 8'h4D;
            2'd2: b = 8'h52;
            2'd3: b = 8'h44;
            default: b = 8'h44;
        endcase
        return b;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic bank,
                                                   input logic [IDX_W-1:0] off);
        logic [MEM_AW-1:0] a;
        a = MEM_AW'(off);
        if (bank) begin
            a = a + MEM_AW'(PAYLOAD_BYTES);
        end
        return a;
    endfunction

endpackage

// ===== design/voice_frame_receive_deframer.sv =====
`timescale 1ns / 1ps
// Receives datagram bytes and millisecond ticks and emits stream start, stream end and voice
// payload beats. A forwarded voice frame yields 33 payload beats, or 34 with a stream start.
// For a frame in an already open stream, the output sequencer first fetches the first payload
// byte and then sends one beat per cycle while the output is not stalled. When the frame opens
// a stream, the start beat is registered while that byte is fetched. Each forwarded payload
// sits in one of two 33-byte banks, and frame events pass through a four-entry event queue.
// Input beats, ticks included, stall while that queue is full. They also stall while the
// datagram being assembled has reached its payload bytes and both banks still await
// transmission. Start and end events are each a single output beat.

`include "voice_frame_receive_deframer_defines.svh"

module voice_frame_receive_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // end_of_datagram
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // source_id, target_id, payload_byte
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_not_empty;
    vfrd_pkg::cmd_t       q_in;
    vfrd_pkg::cmd_t       q_head;
    vfrd_pkg::mem_wr_t    mem_wr;
    vfrd_pkg::back_stat_t back_stat;
    vfrd_pkg::kind_t      out_kind;
    logic [23:0]          out_source;
    logic [23:0]          out_target;
    logic [7:0]           out_payload;

    vfrd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .req_type        (s_tuser),
        .data_byte       (s_tdata),
        .end_of_datagram (s_tlast),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_in),
        .mem_wr          (mem_wr),
        .back_stat       (back_stat)
    );

    vfrd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .pop       (q_pop),
        .head_cmd  (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    vfrd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (q_head),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .mem_wr      (mem_wr),
        .back_stat   (back_stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_source  (out_source),
        .out_target  (out_target),
        .out_payload (out_payload),
        .out_last    (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {out_payload, out_target, out_source};

    `VFRD_ASSERT_SAME(a_full_stalls_input, aclk, aresetn, q_full, !s_tready)

    `VFRD_ASSERT_SAME(a_event_has_no_payload, aclk, aresetn,
        m_tvalid && (m_tuser != vfrd_pkg::KIND_PAYLOAD), m_tdata[55:48] == 8'd0)

    `VFRD_ASSERT_NEXT(a_bank_release_on_last, aclk, aresetn, back_stat.done,
        m_tvalid && m_tlast && (m_tuser == vfrd_pkg::KIND_PAYLOAD))

    `VFRD_ASSERT_SAME(a_no_pop_when_empty, aclk, aresetn, q_pop, q_not_empty)

endmodule

// ===== design/vfrd_queue.sv =====
`timescale 1ns / 1ps

module vfrd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  vfrd_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output vfrd_pkg::cmd_t  head_cmd,
    output logic            not_empty,
    output logic            full
);

    vfrd_pkg::cmd_t                entry_reg [vfrd_pkg::Q_DEPTH];
    logic [vfrd_pkg::Q_AW-1:0]     wptr_reg, wptr_next;
    logic [vfrd_pkg::Q_AW-1:0]     rptr_reg, rptr_next;
    logic [vfrd_pkg::Q_AW:0]       count_reg, count_next;

    assign head_cmd  = entry_reg[rptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (vfrd_pkg::Q_AW + 1)'(vfrd_pkg::Q_DEPTH));

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/vfrd_front.sv =====
`timescale 1ns / 1ps

module vfrd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_datagram,
    input  logic                 q_full,
    output logic                 q_push,
    output vfrd_pkg::cmd_t       q_cmd,
    output vfrd_pkg::mem_wr_t    mem_wr,
    input  vfrd_pkg::back_stat_t back_stat
);

    logic        rx_enabled_reg;
    logic [15:0] timeout_reg;

    logic [vfrd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic        tag_ok_reg, tag_ok_next;
    logic [23:0] fsrc_reg, fsrc_next;
    logic [23:0] ftgt_reg, ftgt_next;
    logic [7:0]  fflags_reg, fflags_next;
    logic        active_reg, active_next;
    logic [1:0]  skip_reg, skip_next;
    logic [23:0] csrc_reg, csrc_next;
    logic [23:0] ctgt_reg, ctgt_next;
    logic [15:0] count_reg, count_next;
    logic        wbank_reg, wbank_next;
    logic [1:0]  busy_reg, busy_next;

    logic        accept;
    logic        frame_done;
    logic [1:0]  ftype;
    logic [3:0]  dtype;
    logic [15:0] timer_load;
    logic [vfrd_pkg::POS_W-1:0] pos_inc;

    assign in_ready = !q_full
        && !(busy_reg[wbank_reg] && (pos_reg >= vfrd_pkg::POS_W'(vfrd_pkg::PAYLOAD_START)));
    assign accept     = in_valid && in_ready;
    assign ftype      = fflags_reg[5:4];
    assign dtype      = fflags_reg[3:0];
    assign timer_load = (timeout_reg == '0) ? 16'd1 : timeout_reg;
    assign pos_inc    = pos_reg + 1'b1;

    always_comb begin
        pos_next    = pos_reg;
        tag_ok_next = tag_ok_reg;
        fsrc_next   = fsrc_reg;
        ftgt_next   = ftgt_reg;
        fflags_next = fflags_reg;
        active_next = active_reg;
        skip_next   = skip_reg;
        csrc_next   = csrc_reg;
        ctgt_next   = ctgt_reg;
        count_next  = count_reg;
        wbank_next  = wbank_reg;
        busy_next   = busy_reg;
        q_push      = 1'b0;
        q_cmd.op    = vfrd_pkg::OP_START;
        q_cmd.src   = csrc_reg;
        q_cmd.tgt   = ctgt_reg;
        q_cmd.bank  = wbank_reg;
        mem_wr.en   = 1'b0;
        mem_wr.addr = vfrd_pkg::mem_addr(wbank_reg,
                          vfrd_pkg::IDX_W'(pos_reg - vfrd_pkg::POS_W'(vfrd_pkg::PAYLOAD_START)));
        mem_wr.data = data_byte;
        frame_done  = 1'b0;

        if (back_stat.done) begin
            busy_next[back_stat.bank] = 1'b0;
        end

        if (accept && (req_type == vfrd_pkg::REQ_TICK)) begin
            if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
                if ((count_reg == 16'd1) && active_reg) begin
                    active_next = 1'b0;
                    q_push      = 1'b1;
                    q_cmd.op    = vfrd_pkg::OP_END;
                end
            end
        end else if (accept) begin
            if (pos_reg < vfrd_pkg::POS_W'(vfrd_pkg::FRAME_BYTES)) begin
                if (pos_reg < vfrd_pkg::POS_W'(vfrd_pkg::TAG_BYTES)) begin
                    if (data_byte != vfrd_pkg::tag_byte(pos_reg[1:0])) begin
                        tag_ok_next = 1'b0;
                    end
                end else if ((pos_reg >= vfrd_pkg::POS_W'(vfrd_pkg::POS_SRC_LO))
                             && (pos_reg <= vfrd_pkg::POS_W'(vfrd_pkg::POS_SRC_HI))) begin
                    fsrc_next = {fsrc_reg[15:0], data_byte};
                end else if ((pos_reg >= vfrd_pkg::POS_W'(vfrd_pkg::POS_TGT_LO))
                             && (pos_reg <= vfrd_pkg::POS_W'(vfrd_pkg::POS_TGT_HI))) begin
                    ftgt_next = {ftgt_reg[15:0], data_byte};
                end else if (pos_reg == vfrd_pkg::POS_W'(vfrd_pkg::POS_FLAGS)) begin
                    fflags_next = data_byte;
                end else if (pos_reg >= vfrd_pkg::POS_W'(vfrd_pkg::PAYLOAD_START)) begin
                    mem_wr.en = 1'b1;
                end
                pos_next = pos_inc;
            end
            if (end_of_datagram) begin
                frame_done  = tag_ok_reg
                    && (pos_next >= vfrd_pkg::POS_W'(vfrd_pkg::FRAME_BYTES));
                pos_next    = '0;
                tag_ok_next = 1'b1;
            end
        end

        if (frame_done) begin
            if (ftype == vfrd_pkg::FTYPE_CTRL) begin
                if (dtype == vfrd_pkg::DT_HEADER) begin
                    skip_next   = vfrd_pkg::SKIP_AFTER_HEADER;
                    csrc_next   = fsrc_reg;
                    ctgt_next   = ftgt_reg;
                    active_next = 1'b1;
                    count_next  = timer_load;
                    q_push      = 1'b1;
                    q_cmd.op    = vfrd_pkg::OP_START;
                    q_cmd.src   = fsrc_reg;
                    q_cmd.tgt   = ftgt_reg;
                end else if (dtype == vfrd_pkg::DT_TERMINATOR) begin
                    skip_next   = '0;
                    active_next = 1'b0;
                    count_next  = '0;
                    q_push      = 1'b1;
                    q_cmd.op    = vfrd_pkg::OP_END;
                end
            end else if ((ftype != vfrd_pkg::FTYPE_DATA) && rx_enabled_reg) begin
                if (skip_reg != '0) begin
                    skip_next = skip_reg - 1'b1;
                end else begin
                    q_push   = 1'b1;
                    q_cmd.op = vfrd_pkg::OP_VOICE;
                    if (!active_reg) begin
                        csrc_next   = fsrc_reg;
                        ctgt_next   = ftgt_reg;
                        active_next = 1'b1;
                        q_cmd.op    = vfrd_pkg::OP_VOICE_OPEN;
                        q_cmd.src   = fsrc_reg;
                        q_cmd.tgt   = ftgt_reg;
                    end
                    count_next           = timer_load;
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_enabled_reg <= 1'b1;
            timeout_reg    <= vfrd_pkg::TIMEOUT_RESET;
            pos_reg        <= '0;
            tag_ok_reg     <= 1'b1;
            fsrc_reg       <= '0;
            ftgt_reg       <= '0;
            fflags_reg     <= '0;
            active_reg     <= 1'b0;
            skip_reg       <= '0;
            csrc_reg       <= '0;
            ctgt_reg       <= '0;
            count_reg      <= '0;
            wbank_reg      <= 1'b0;
            busy_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    vfrd_pkg::REG_RX_ENABLED: rx_enabled_reg <= cfg_wdata[0];
                    vfrd_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_wdata;
                    default:                  timeout_reg    <= timeout_reg;
                endcase
            end
            pos_reg    <= pos_next;
            tag_ok_reg <= tag_ok_next;
            fsrc_reg   <= fsrc_next;
            ftgt_reg   <= ftgt_next;
            fflags_reg <= fflags_next;
            active_reg <= active_next;
            skip_reg   <= skip_next;
            csrc_reg   <= csrc_next;
            ctgt_reg   <= ctgt_next;
            count_reg  <= count_next;
            wbank_reg  <= wbank_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

// ===== design/vfrd_back.sv =====
`timescale 1ns / 1ps

module vfrd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vfrd_pkg::cmd_t       head_cmd,
    input  logic                 q_not_empty,
    output logic                 q_pop,
    input  vfrd_pkg::mem_wr_t    mem_wr,
    output vfrd_pkg::back_stat_t back_stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vfrd_pkg::kind_t      out_kind,
    output logic [23:0]          out_source,
    output logic [23:0]          out_target,
    output logic [7:0]           out_payload,
    output logic                 out_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PAY  = 2'b10
    } state_t;

    logic [7:0] mem [vfrd_pkg::MEM_DEPTH];

    state_t                     state_reg, state_next;
    logic [vfrd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       bank_reg, bank_next;
    logic [23:0]                src_reg, src_next;
    logic [23:0]                tgt_reg, tgt_next;
    logic [7:0]                 rd_data_reg;

    logic            valid_reg, valid_next;
    vfrd_pkg::kind_t kind_reg, kind_next;
    logic [23:0]     osrc_reg, osrc_next;
    logic [23:0]     otgt_reg, otgt_next;
    logic [7:0]      obyte_reg, obyte_next;
    logic            olast_reg, olast_next;

    logic out_free;
    logic rd_en;
    logic [vfrd_pkg::MEM_AW-1:0] rd_addr;

    assign out_free    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_source  = osrc_reg;
    assign out_target  = otgt_reg;
    assign out_payload = obyte_reg;
    assign out_last    = olast_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        bank_next      = bank_reg;
        src_next       = src_reg;
        tgt_next       = tgt_reg;
        valid_next     = valid_reg && !out_ready;
        kind_next      = kind_reg;
        osrc_next      = osrc_reg;
        otgt_next      = otgt_reg;
        obyte_next     = obyte_reg;
        olast_next     = olast_reg;
        q_pop          = 1'b0;
        back_stat.done = 1'b0;
        back_stat.bank = bank_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty && out_free) begin
                    q_pop     = 1'b1;
                    src_next  = head_cmd.src;
                    tgt_next  = head_cmd.tgt;
                    bank_next = head_cmd.bank;
                    idx_next  = '0;
                    osrc_next = head_cmd.src;
                    otgt_next = head_cmd.tgt;
                    obyte_next = '0;
                    unique case (head_cmd.op)
                        vfrd_pkg::OP_START: begin
                            valid_next = 1'b1;
                            kind_next  = vfrd_pkg::KIND_START;
                            olast_next = 1'b1;
                        end
                        vfrd_pkg::OP_END: begin
                            valid_next = 1'b1;
                            kind_next  = vfrd_pkg::KIND_END;
                            olast_next = 1'b1;
                        end
                        vfrd_pkg::OP_VOICE_OPEN: begin
                            valid_next = 1'b1;
                            kind_next  = vfrd_pkg::KIND_START;
                            olast_next = 1'b0;
                            state_next = ST_PAY;
                        end
                        vfrd_pkg::OP_VOICE: begin
                            state_next = ST_PAY;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAY: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = vfrd_pkg::KIND_PAYLOAD;
                    osrc_next  = src_reg;
                    otgt_next  = tgt_reg;
                    obyte_next = rd_data_reg;
                    olast_next = (idx_reg == vfrd_pkg::IDX_W'(vfrd_pkg::PAYLOAD_BYTES - 1));
                    idx_next   = idx_reg + 1'b1;
                    if (olast_next) begin
                        state_next     = ST_IDLE;
                        back_stat.done = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_en   = (state_next == ST_PAY)
        && (idx_next < vfrd_pkg::IDX_W'(vfrd_pkg::PAYLOAD_BYTES));
    assign rd_addr = vfrd_pkg::mem_addr(bank_next, idx_next);

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg   <= src_next;
        tgt_reg   <= tgt_next;
        kind_reg  <= kind_next;
        osrc_reg  <= osrc_next;
        otgt_reg  <= otgt_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule
